// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: hw/rtl/lruc_pkg.sv
// ----------------------------------------------------------------------------
// lruc_pkg
// types and constants shared by the lru cache cells and top level
// ----------------------------------------------------------------------------
package lruc_pkg;

  localparam int KEY_W      = 64;
  localparam int VAL_W      = 64;
  localparam int CNT_W      = 16;
  localparam int CFG_SIZE_W = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2,
    OP_CLEAR  = 2'd3
  } lruc_op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ABSENT   = 2'd1,
    ST_REPLACED = 2'd2
  } lruc_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_SIZE  = 4'd0,
    CFG_FORGET_LIMIT = 4'd1
  } lruc_cfg_idx_e;

  // what every cell does in the update cycle
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_FRONT  = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_CLEAR  = 3'd4
  } lruc_act_e;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;
  } lruc_entry_t;

  // broadcast from the controller to all cells
  typedef struct packed {
    logic             cmp_en;
    logic [KEY_W-1:0] cmp_key;
    logic [CNT_W-1:0] limit;
    lruc_act_e        act;
  } lruc_cmd_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value_out;
    logic [1:0]       status;
    logic             expired;
    logic             evicted;
  } lruc_rsp_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = (c == '1) ? c : c + CNT_W'(1);
    return r;
  endfunction

endpackage

// File: hw/rtl/lruc_if.sv
// ----------------------------------------------------------------------------
// lruc_if
// valid/ready channels for requests, results and configuration writes
// ----------------------------------------------------------------------------
interface lruc_req_if import lruc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value_in;

  modport source (output valid, opcode, key, value_in, input ready);
  modport sink   (input valid, opcode, key, value_in, output ready);
endinterface

interface lruc_rsp_if import lruc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [VAL_W-1:0] value_out;
  logic [1:0]       status;
  logic             expired;
  logic             evicted;

  modport source (output valid, hit, value_out, status, expired, evicted, input ready);
  modport sink   (input valid, hit, value_out, status, expired, evicted, output ready);
endinterface

interface lruc_cfg_if import lruc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/lruc_cell.sv
// ----------------------------------------------------------------------------
// lruc_cell
// one recency position of the cache; shifts entries to and from neighbors
// ----------------------------------------------------------------------------
module lruc_cell import lruc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lruc_cmd_t   cmd_i,
  input  logic        keep_i,
  input  lruc_entry_t prev_i,
  input  lruc_entry_t next_i,
  input  logic        seen_i,
  output lruc_entry_t entry_o,
  output logic        seen_o,
  output logic        match_o,
  output logic        expire_o,
  output logic        drop_o
);

  logic             valid_q, valid_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [VAL_W-1:0] value_q, value_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             match_q, expire_q;
  logic [CNT_W-1:0] count_inc;
  logic             match_c;
  logic             take_prev;
  logic             take_next;

  assign count_inc = sat_inc(count_q);
  assign match_c   = valid_q && (key_q == cmd_i.cmp_key);

  // cells up to and including the hit take from the previous position
  assign take_prev = !seen_i;
  // cells from the removed one on pull up from the next position
  assign take_next = seen_i || match_q;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    count_d = count_q;
    drop_o  = 1'b0;
    case (cmd_i.act)
      ACT_FRONT: begin
        if (take_prev) begin
          valid_d = prev_i.valid;
          key_d   = prev_i.key;
          value_d = prev_i.value;
          count_d = prev_i.count;
        end
      end
      ACT_INSERT: begin
        if (take_prev) begin
          valid_d = prev_i.valid;
          key_d   = prev_i.key;
          value_d = prev_i.value;
          count_d = prev_i.count;
        end
        drop_o  = valid_d && !keep_i;
        valid_d = valid_d && keep_i;
      end
      ACT_REMOVE: begin
        if (take_next) begin
          valid_d = next_i.valid;
          key_d   = next_i.key;
          value_d = next_i.value;
          count_d = next_i.count;
        end
      end
      ACT_CLEAR: begin
        valid_d = 1'b0;
      end
      ACT_NONE: begin
        valid_d = valid_q;
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      match_q  <= 1'b0;
      expire_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.cmp_en) begin
        match_q  <= match_c;
        expire_q <= match_c && (cmd_i.limit != '0) && (count_inc >= cmd_i.limit);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
    count_q <= count_d;
  end

  assign entry_o.valid = valid_q;
  assign entry_o.key   = key_q;
  assign entry_o.value = value_q;
  assign entry_o.count = count_q;
  assign seen_o        = seen_i || match_q;
  assign match_o       = match_q;
  assign expire_o      = expire_q;

endmodule

// File: hw/rtl/lru_cache_with_hit_expiry.sv
// ----------------------------------------------------------------------------
// lru_cache_with_hit_expiry
// fully associative key/value cache with lru replacement and hit expiry
// ----------------------------------------------------------------------------
// A request passes through a compare cycle, in which every cell checks its
// key and its hit count against the request, and an update cycle in which the
// cells shift entries one position toward or away from the front of the
// recency chain and the result is written to the output register. The next
// request is taken during the update cycle while results are taken; a waiting
// result holds the update cycle. Entries sit in cells ordered by recency, cell
// 0 the most recent. Config writes are taken in any cycle and are meant to
// happen while no request is in flight.
module lru_cache_with_hit_expiry import lruc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  lruc_req_if.sink   req_i,
  lruc_rsp_if.source rsp_o,
  lruc_cfg_if.sink   cfg_i
);

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CFG_SIZE_W-1:0] active_size_q;
  logic [CNT_W-1:0]      forget_limit_q;

  lruc_op_e         op_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_in_q;

  logic      rsp_valid_q;
  lruc_rsp_t rsp_q, rsp_d;

  lruc_cmd_t   cmd;
  lruc_act_e   act_c;
  lruc_entry_t head;
  lruc_entry_t ents  [ENTRIES];
  logic [ENTRIES:0]   seen;
  logic [ENTRIES-1:0] keep, match, expire, drop, valid_vec;

  logic             req_acc, out_free, do_upd;
  logic             any_match, any_exp, falloff;
  logic [VAL_W-1:0] hit_value;
  logic [CNT_W-1:0] hit_count;

  // ---------------- configuration ----------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_size_q  <= CFG_SIZE_W'(16);
      forget_limit_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ACTIVE_SIZE:  active_size_q  <= cfg_i.data[CFG_SIZE_W-1:0];
        CFG_FORGET_LIMIT: forget_limit_q <= cfg_i.data[CNT_W-1:0];
        default: begin
          active_size_q <= active_size_q;
        end
      endcase
    end
  end

  // positions kept after an insert, active size clamped to 2..ENTRIES
  for (genvar g = 0; g < ENTRIES; g++) begin : g_keep
    if (g < 2) begin : g_lo
      assign keep[g] = 1'b1;
    end else if (g < 32) begin : g_mid
      assign keep[g] = active_size_q > CFG_SIZE_W'(g);
    end else begin : g_hi
      assign keep[g] = 1'b0;
    end
  end

  // ---------------- control ----------------
  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign do_upd      = (state_q == S_UPD) && out_free;
  assign req_i.ready = (state_q == S_IDLE) || do_upd;
  assign req_acc     = req_i.valid && req_i.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (req_acc) state_d = S_CMP;
      S_CMP:   state_d = S_UPD;
      S_UPD:   if (out_free) state_d = req_acc ? S_CMP : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_upd) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      op_q       <= lruc_op_e'(req_i.opcode);
      key_q      <= req_i.key;
      value_in_q <= req_i.value_in;
    end
    if (do_upd) begin
      rsp_q <= rsp_d;
    end
  end

  // ---------------- hit selection ----------------
  always_comb begin
    hit_value = '0;
    hit_count = '0;
    any_exp   = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_value = hit_value | (match[i] ? ents[i].value : '0);
      hit_count = hit_count | (match[i] ? ents[i].count : '0);
      any_exp   = any_exp | expire[i];
    end
  end

  assign any_match = seen[ENTRIES];
  // an insert pushes the last valid entry off the end of the chain
  assign falloff   = !seen[ENTRIES] && ents[ENTRIES-1].valid;

  always_comb begin
    act_c            = ACT_NONE;
    head.valid       = 1'b1;
    head.key         = key_q;
    head.value       = value_in_q;
    head.count       = '0;
    rsp_d            = '0;
    case (op_q)
      OP_FIND: begin
        head.value = hit_value;
        head.count = sat_inc(hit_count);
        if (any_match) begin
          act_c = any_exp ? ACT_REMOVE : ACT_FRONT;
        end
        rsp_d.hit       = any_match;
        rsp_d.value_out = any_match ? hit_value : '0;
        rsp_d.expired   = any_exp;
      end
      OP_INSERT: begin
        act_c         = ACT_INSERT;
        rsp_d.status  = any_match ? ST_REPLACED : ST_OK;
        rsp_d.evicted = (|drop) || falloff;
      end
      OP_ERASE: begin
        act_c        = any_match ? ACT_REMOVE : ACT_NONE;
        rsp_d.status = any_match ? ST_OK : ST_ABSENT;
      end
      OP_CLEAR: begin
        act_c = ACT_CLEAR;
      end
      default: begin
        act_c = ACT_NONE;
      end
    endcase
  end

  assign cmd.cmp_en  = (state_q == S_CMP);
  assign cmd.cmp_key = key_q;
  assign cmd.limit   = forget_limit_q;
  assign cmd.act     = do_upd ? act_c : ACT_NONE;

  // ---------------- cell chain ----------------
  assign seen[0] = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lruc_entry_t prev_e, next_e;

    if (g == 0) begin : g_first
      assign prev_e = head;
    end else begin : g_prev
      assign prev_e = ents[g-1];
    end

    if (g == ENTRIES - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_next
      assign next_e = ents[g+1];
    end

    lruc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .keep_i   (keep[g]),
      .prev_i   (prev_e),
      .next_i   (next_e),
      .seen_i   (seen[g]),
      .entry_o  (ents[g]),
      .seen_o   (seen[g+1]),
      .match_o  (match[g]),
      .expire_o (expire[g]),
      .drop_o   (drop[g])
    );

    assign valid_vec[g] = ents[g].valid;
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.hit       = rsp_q.hit;
  assign rsp_o.value_out = rsp_q.value_out;
  assign rsp_o.status    = rsp_q.status;
  assign rsp_o.expired   = rsp_q.expired;
  assign rsp_o.evicted   = rsp_q.evicted;

  // ---------------- assertions ----------------
  // keys among valid entries are unique
  `ASSERT_IMPL(a_match_unique, clk_i, rst_ni, state_q == S_UPD, $onehot0(match))
  // valid entries always fill the front of the chain
  `ASSERT_IMPL(a_valid_packed, clk_i, rst_ni, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0)
  // an expiry only comes with a hit
  `ASSERT_IMPL(a_exp_needs_hit, clk_i, rst_ni, state_q == S_UPD && any_exp, any_match)
  // no request is taken while the compare is running
  `ASSERT_IMPL(a_no_acc_in_cmp, clk_i, rst_ni, state_q == S_CMP, !req_i.ready)
  // every update cycle that completes leaves a result behind
  `ASSERT_NEXT(a_upd_gives_rsp, clk_i, rst_ni, do_upd, rsp_valid_q)

endmodule

// File: verif/tb_lru_cache_with_hit_expiry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_cache_with_hit_expiry
// self-checking bench: directed and random find/insert/erase/clear traffic
// under several size and expiry settings, results compared against an lru
// predictor kept in the scoreboard
// ----------------------------------------------------------------------------
module tb_lru_cache_with_hit_expiry;
  import lruc_pkg::*;

  localparam int ENTRIES         = 16;
  localparam int TIMEOUT_CYCLES  = 2_000_000;
  localparam int HOLD_CYCLES     = 300;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int POOL_SIZE       = 24;

  class cache_scoreboard;
    logic [KEY_W-1:0] keys   [ENTRIES];
    logic [VAL_W-1:0] vals   [ENTRIES];
    logic [CNT_W-1:0] counts [ENTRIES];
    bit               live   [ENTRIES];
    int               rank   [ENTRIES];
    int               size_reg;
    int               limit_reg;
    int               errors;
    lruc_rsp_t        expect_q[$];

    function new();
      size_reg  = 16;
      limit_reg = 0;
      errors    = 0;
      for (int i = 0; i < ENTRIES; i++) live[i] = 0;
    endfunction

    function int slot_of(logic [KEY_W-1:0] key);
      for (int i = 0; i < ENTRIES; i++)
        if (live[i] && keys[i] == key) return i;
      return -1;
    endfunction

    function int occupied();
      int n;
      n = 0;
      for (int i = 0; i < ENTRIES; i++) if (live[i]) n++;
      return n;
    endfunction

    function void drop(int s);
      int r;
      r = rank[s];
      live[s] = 0;
      for (int i = 0; i < ENTRIES; i++)
        if (live[i] && rank[i] > r) rank[i]--;
    endfunction

    function void to_front(int s);
      int r;
      r = rank[s];
      for (int i = 0; i < ENTRIES; i++)
        if (live[i] && i != s && rank[i] < r) rank[i]++;
      rank[s] = 0;
    endfunction

    function int oldest();
      int best;
      best = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (live[i] && (best < 0 || rank[i] > rank[best])) best = i;
      return best;
    endfunction

    function void write_reg(lruc_cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ACTIVE_SIZE:  size_reg  = int'(data[CFG_SIZE_W-1:0]);
        CFG_FORGET_LIMIT: limit_reg = int'(data);
        default: ;
      endcase
    endfunction

    function void note_request(lruc_op_e op, logic [KEY_W-1:0] key,
                               logic [VAL_W-1:0] val);
      lruc_rsp_t r;
      int        s;
      int        cap;
      r = '0;
      case (op)
        OP_FIND: begin
          s = slot_of(key);
          if (s >= 0) begin
            r.hit       = 1'b1;
            r.value_out = vals[s];
            if (counts[s] != '1) counts[s] = counts[s] + 1'b1;
            to_front(s);
            if (limit_reg != 0 && int'(counts[s]) >= limit_reg) begin
              drop(s);
              r.expired = 1'b1;
            end
          end
        end
        OP_INSERT: begin
          cap = (size_reg < 2) ? 2 : (size_reg > ENTRIES) ? ENTRIES : size_reg;
          s = slot_of(key);
          if (s >= 0) begin
            drop(s);
            r.status = ST_REPLACED;
          end
          while (occupied() >= cap) begin
            drop(oldest());
            r.evicted = 1'b1;
          end
          s = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (!live[i]) begin
              s = i;
              break;
            end
          for (int i = 0; i < ENTRIES; i++) if (live[i]) rank[i]++;
          keys[s]   = key;
          vals[s]   = val;
          counts[s] = '0;
          rank[s]   = 0;
          live[s]   = 1;
        end
        OP_ERASE: begin
          s = slot_of(key);
          if (s >= 0) drop(s);
          else r.status = ST_ABSENT;
        end
        default: begin
          for (int i = 0; i < ENTRIES; i++) live[i] = 0;
        end
      endcase
      expect_q.push_back(r);
    endfunction

    function void check_result(logic hit, logic [VAL_W-1:0] value_out,
                               logic [1:0] status, logic expired, logic evicted);
      lruc_rsp_t want;
      if (expect_q.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
        return;
      end
      want = expect_q.pop_front();
      if (hit !== want.hit) begin
        $error("hit: expected %0d, actual %0d", want.hit, hit);
        errors++;
      end
      if (value_out !== want.value_out) begin
        $error("value_out: expected %h, actual %h", want.value_out, value_out);
        errors++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        errors++;
      end
      if (expired !== want.expired) begin
        $error("expired: expected %0d, actual %0d", want.expired, expired);
        errors++;
      end
      if (evicted !== want.evicted) begin
        $error("evicted: expected %0d, actual %0d", want.evicted, evicted);
        errors++;
      end
    endfunction

    function int pending();
      return expect_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  lruc_req_if req ();
  lruc_rsp_if rsp ();
  lruc_cfg_if cfg ();

  cache_scoreboard  sb;
  int               send_pct = 0;
  int               recv_pct = 0;
  bit               hold_go  = 0;
  bit               hold_rsp = 0;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int               pool_n   = POOL_SIZE;

  lru_cache_with_hit_expiry #(.ENTRIES(ENTRIES)) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp),
    .cfg_i (cfg)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready <= !hold_rsp && ($urandom_range(99) >= recv_pct);
    end
  end

  // long back-pressure stretch on the result side
  initial begin : hold_off
    int n;
    wait (hold_go);
    @(posedge clk);
    hold_rsp = 1'b1;
    for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
    hold_rsp = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && rsp.valid && rsp.ready)
      sb.check_result(rsp.hit, rsp.value_out, rsp.status, rsp.expired, rsp.evicted);
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < TIMEOUT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("lru_cache_with_hit_expiry test failed");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_req(input lruc_op_e op, input logic [KEY_W-1:0] key,
                          input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid    <= 1'b1;
    req.opcode   <= op;
    req.key      <= key;
    req.value_in <= val;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(op, key, val);
    @(negedge clk);
  endtask

  task automatic random_request();
    int               r;
    lruc_op_e         op;
    logic [KEY_W-1:0] k;
    r  = $urandom_range(99);
    op = (r < 45) ? OP_FIND : (r < 80) ? OP_INSERT : (r < 96) ? OP_ERASE : OP_CLEAR;
    // mostly keys from a small pool so hits, replaces and evictions happen
    k  = ($urandom_range(9) == 0) ? rand64() : key_pool[$urandom_range(pool_n - 1)];
    send_req(op, k, rand64());
  endtask

  task automatic wait_quiet();
    req.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic set_reg(input lruc_cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int phase_size  [PHASES];
    int phase_limit [PHASES];

    sb = new();
    rst_n        = 1'b0;
    req.valid    = 1'b0;
    req.opcode   = OP_FIND;
    req.key      = '0;
    req.value_in = '0;
    cfg.valid    = 1'b0;
    cfg.index    = CFG_ACTIVE_SIZE;
    cfg.data     = '0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = rand64();
    key_pool[0] = '0;
    key_pool[1] = '1;
    phase_size  = '{16, 2, 5, 0, 31, 8, 1, 17, 3, 0, 12, 16};
    phase_limit = '{0, 1, 65535, 2, 0, 3, 0, 1, 5, 0, 0, 2};
    phase_size[9]  = $urandom_range(2, 16);
    phase_limit[9] = $urandom_range(1, 8);

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty store, extreme keys and values, replace, erase, clear
    send_req(OP_FIND,   key_pool[0], rand64());
    send_req(OP_ERASE,  key_pool[1], rand64());
    send_req(OP_INSERT, key_pool[0], '1);
    send_req(OP_INSERT, key_pool[1], '0);
    send_req(OP_FIND,   key_pool[0], rand64());
    send_req(OP_FIND,   key_pool[1], rand64());
    send_req(OP_INSERT, key_pool[0], 64'h5555_5555_5555_5555);
    send_req(OP_FIND,   key_pool[0], rand64());
    send_req(OP_ERASE,  key_pool[1], rand64());
    send_req(OP_CLEAR,  key_pool[2], rand64());
    send_req(OP_FIND,   key_pool[0], rand64());
    wait_quiet();

    // smallest size with expiry on first hit
    set_reg(CFG_ACTIVE_SIZE, 16'd2);
    set_reg(CFG_FORGET_LIMIT, 16'd1);
    send_req(OP_INSERT, key_pool[2], rand64());
    send_req(OP_INSERT, key_pool[3], rand64());
    send_req(OP_INSERT, key_pool[4], rand64());
    send_req(OP_FIND,   key_pool[2], rand64());
    send_req(OP_FIND,   key_pool[3], rand64());
    wait_quiet();

    // size below range clamps to two
    set_reg(CFG_ACTIVE_SIZE, 16'd0);
    set_reg(CFG_FORGET_LIMIT, 16'd0);
    send_req(OP_INSERT, key_pool[5], rand64());
    send_req(OP_INSERT, key_pool[6], rand64());
    send_req(OP_INSERT, key_pool[7], rand64());
    wait_quiet();

    // size above range clamps to ENTRIES, then a lowered size evicts several
    set_reg(CFG_ACTIVE_SIZE, 16'd31);
    set_reg(CFG_FORGET_LIMIT, 16'hffff);
    send_req(OP_INSERT, key_pool[8], rand64());
    send_req(OP_INSERT, key_pool[9], rand64());
    send_req(OP_INSERT, key_pool[10], rand64());
    wait_quiet();
    set_reg(CFG_ACTIVE_SIZE, 16'd3);
    send_req(OP_INSERT, key_pool[11], rand64());
    send_req(OP_FIND,   key_pool[6], rand64());
    wait_quiet();

    for (int p = 0; p < PHASES; p++) begin
      set_reg(CFG_ACTIVE_SIZE, 16'(phase_size[p]));
      set_reg(CFG_FORGET_LIMIT, 16'(phase_limit[p]));
      pool_n = $urandom_range(3, POOL_SIZE);
      case (p % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 62; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 62; end
        default: begin send_pct = 9; recv_pct = 9; end
      endcase
      // first phase: results held off so the block backs up into its input
      if (p == 0) hold_go = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) random_request();
      wait_quiet();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("lru_cache_with_hit_expiry test passed");
    else
      $display("lru_cache_with_hit_expiry test failed");
    $finish;
  end

endmodule
